### design/ptw3_pkg.sv
// ptw3_pkg: shared types, field widths and codes of the three-level table walker
// no dependencies; imported by the interfaces and every module of the walker
package ptw3_pkg;

   localparam int PA_W   = 48;
   localparam int VA_W   = 64;
   localparam int DESC_W = 64;
   localparam int IDX_W  = 9;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // input function codes
   localparam logic FUNC_TRANSLATE = 1'b0;
   localparam logic FUNC_DESC_RSP  = 1'b1;

   // result kinds
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // mapping sizes
   localparam logic [1:0] SIZE_4K = 2'd0;
   localparam logic [1:0] SIZE_2M = 2'd1;
   localparam logic [1:0] SIZE_1G = 2'd2;

   // walk levels
   localparam logic [1:0] LEVEL_1 = 2'd1;
   localparam logic [1:0] LEVEL_2 = 2'd2;
   localparam logic [1:0] LEVEL_3 = 2'd3;

   // register indexes, selected by paddr bit 3
   localparam logic CSR_LOW_BASE  = 1'b0;
   localparam logic CSR_HIGH_BASE = 1'b1;

   // classified item held in the queue between front and back
   typedef struct packed {
      logic              is_rsp;
      logic [PA_W-1:0]   rd_addr;  // level 1 read address for translate items
      logic [DESC_W-1:0] data;     // virtual address or descriptor
   } ptw3_entry_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic           valid;
      ptw3_entry_type entry;
   } ptw3_head_type;

endpackage

### design/ptw3_req_if.sv
// ptw3_req_if: request channel of the walker (translate requests and descriptor responses)
// depends on ptw3_pkg
interface ptw3_req_if
   import ptw3_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              func;
   logic [VA_W-1:0]   virt_addr;
   logic [DESC_W-1:0] descriptor;

   modport source (output valid, func, virt_addr, descriptor, input ready);
   modport sink   (input valid, func, virt_addr, descriptor, output ready);
endinterface

### design/ptw3_rsp_if.sv
// ptw3_rsp_if: result channel of the walker (descriptor reads and finished translations)
// depends on ptw3_pkg
interface ptw3_rsp_if
   import ptw3_pkg::*;
();
   logic            valid;
   logic            ready;
   logic            kind;
   logic [PA_W-1:0] address;
   logic            fault;
   logic [1:0]      page_size;

   modport source (output valid, kind, address, fault, page_size, input ready);
   modport sink   (input valid, kind, address, fault, page_size, output ready);
endinterface

### design/ptw3_front.sv
// ptw3_front: accepts items, works out the level 1 read address, queues them in order
// depends on ptw3_pkg and ptw3_req_if
module ptw3_front
   import ptw3_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   ptw3_req_if.sink        req_chan,
   input  logic [PA_W-1:0] low_base,
   input  logic [PA_W-1:0] high_base,
   output ptw3_head_type   head,
   input  logic            pop
);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ptw3_entry_type queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   ptw3_entry_type new_entry;
   logic [PA_W-1:0] base;
   logic push;

   // classify: translate items get their level 1 descriptor address here
   always_comb begin
      base = (|req_chan.virt_addr[VA_W-1:PA_W]) ? high_base : low_base;
      new_entry.is_rsp  = (req_chan.func == FUNC_DESC_RSP);
      new_entry.rd_addr = base + {{(PA_W-IDX_W-3){1'b0}}, req_chan.virt_addr[38:30], 3'b000};
      new_entry.data    = (req_chan.func == FUNC_DESC_RSP) ? req_chan.descriptor
                                                          : req_chan.virt_addr;
   end

   assign req_chan.ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push = req_chan.valid && req_chan.ready;

   assign head.valid = (count_ff != '0);
   assign head.entry = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

### design/ptw3_back.sv
// ptw3_back: walk state, descriptor decode and the registered result stage
// depends on ptw3_pkg and ptw3_rsp_if
module ptw3_back
   import ptw3_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ptw3_head_type head,
   output logic          pop,
   ptw3_rsp_if.source    rsp_chan
);
   logic              active_ff, active_in;
   logic [1:0]        level_ff, level_in;
   logic [VA_W-1:0]   vaddr_ff, vaddr_in;

   logic              out_valid_ff;
   logic              out_kind_ff, out_fault_ff;
   logic [PA_W-1:0]   out_addr_ff;
   logic [1:0]        out_size_ff;

   logic              res_valid, res_kind, res_fault;
   logic [PA_W-1:0]   res_addr;
   logic [1:0]        res_size;
   logic [DESC_W-1:0] desc;
   logic [IDX_W-1:0]  next_idx;

   assign pop = head.valid && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      active_in = active_ff;
      level_in  = level_ff;
      vaddr_in  = vaddr_ff;
      res_valid = 1'b0;
      res_kind  = KIND_READ;
      res_fault = 1'b0;
      res_addr  = '0;
      res_size  = SIZE_4K;
      desc      = head.entry.data;
      next_idx  = (level_ff == LEVEL_1) ? vaddr_ff[29:21] : vaddr_ff[20:12];

      if (!head.entry.is_rsp) begin
         // new walk, abandons any old one
         active_in = 1'b1;
         level_in  = LEVEL_1;
         vaddr_in  = head.entry.data;
         res_valid = 1'b1;
         res_addr  = head.entry.rd_addr;
      end else if (active_ff) begin
         res_valid = 1'b1;
         if (level_ff != LEVEL_1 && level_ff != LEVEL_2) begin
            active_in = 1'b0;
            level_in  = '0;
            res_kind  = KIND_DONE;
            if (desc[1:0] == 2'b11) begin
               res_addr = {desc[47:12], vaddr_ff[11:0]};
            end else begin
               res_fault = 1'b1;
            end
         end else if (!desc[0]) begin
            active_in = 1'b0;
            level_in  = '0;
            res_kind  = KIND_DONE;
            res_fault = 1'b1;
         end else if (!desc[1]) begin
            active_in = 1'b0;
            level_in  = '0;
            res_kind  = KIND_DONE;
            if (level_ff == LEVEL_1) begin
               res_addr = {desc[47:30], vaddr_ff[29:0]};
               res_size = SIZE_1G;
            end else begin
               res_addr = {desc[47:21], vaddr_ff[20:0]};
               res_size = SIZE_2M;
            end
         end else begin
            // table descriptor: next level read, index lands in bits 11:3
            level_in = (level_ff == LEVEL_1) ? LEVEL_2 : LEVEL_3;
            res_addr = {desc[47:12], next_idx, 3'b000};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         level_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            active_ff <= active_in;
            level_ff  <= level_in;
         end
         if (pop && res_valid) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         vaddr_ff <= vaddr_in;
      end
      if (pop && res_valid) begin
         out_kind_ff  <= res_kind;
         out_fault_ff <= res_fault;
         out_addr_ff  <= res_addr;
         out_size_ff  <= res_size;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.kind      = out_kind_ff;
   assign rsp_chan.fault     = out_fault_ff;
   assign rsp_chan.address   = out_addr_ff;
   assign rsp_chan.page_size = out_size_ff;

endmodule

### design/page_table_walker_3level.sv
// page_table_walker_3level: top level, register port and front/back hookup
// depends on ptw3_pkg, ptw3_req_if, ptw3_rsp_if, ptw3_front and ptw3_back
//
// three-level translation walker, 4 kb granule, 9-bit indexes. one item
// goes in per clock while the queue has room, and each gives at most one
// result item: a translate request (func 0) gives the level 1 descriptor
// read at table base plus va[38:30]*8, the base being high_table_base when
// any of va[63:48] is set; a descriptor response (func 1) gives the next
// read, a 1 gb / 2 mb / 4 kb mapping, or a fault, and is dropped without
// result when no walk is active. a new request abandons a walk in flight.
// the block sustains one item per clock while the result side takes its
// results; an accepted item is registered in the front queue and then in
// the back end's output register. the queue depth (QUEUE_DEPTH, default 2)
// sets how many items the front takes while the result side stalls. registers:
// low_table_base at byte 0x0 and high_table_base at 0x8, 48 bits each in a
// 64-bit data word; write them only while no walk item is pending
module page_table_walker_3level
   import ptw3_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   ptw3_req_if.sink              req_chan,
   ptw3_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);
   logic [PA_W-1:0] low_base_ff;
   logic [PA_W-1:0] high_base_ff;
   logic            csr_write;
   ptw3_head_type   head;
   logic            pop;

   // register port, csr_pready always high
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_base_ff  <= '0;
         high_base_ff <= '0;
      end else if (csr_write) begin
         // register index is paddr bit 3, lower bits ignored
         unique case (csr_paddr[3])
            CSR_LOW_BASE:  low_base_ff  <= csr_pwdata[PA_W-1:0];
            CSR_HIGH_BASE: high_base_ff <= csr_pwdata[PA_W-1:0];
            default:       low_base_ff  <= low_base_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3])
         CSR_LOW_BASE:  csr_prdata = {{(CSR_DATA_W-PA_W){1'b0}}, low_base_ff};
         CSR_HIGH_BASE: csr_prdata = {{(CSR_DATA_W-PA_W){1'b0}}, high_base_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // front: accept, classify, queue
   ptw3_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .low_base  (low_base_ff),
      .high_base (high_base_ff),
      .head      (head),
      .pop       (pop)
   );

   // back: walk state and result register
   ptw3_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
